/* rtl/core/tre_pkg.sv */
package tre_pkg;

    localparam int unsigned RegCount = 15;
    localparam int unsigned RegIdxW  = 4;

    localparam logic [1:0] StatusOk    = 2'd0;
    localparam logic [1:0] StatusUndef = 2'd1;
    localparam logic [1:0] StatusMem   = 2'd2;

    localparam logic [3:0] AluAnd = 4'h0;
    localparam logic [3:0] AluEor = 4'h1;
    localparam logic [3:0] AluLsl = 4'h2;
    localparam logic [3:0] AluLsr = 4'h3;
    localparam logic [3:0] AluAdc = 4'h5;
    localparam logic [3:0] AluSbc = 4'h6;
    localparam logic [3:0] AluTst = 4'h8;
    localparam logic [3:0] AluCmp = 4'hA;
    localparam logic [3:0] AluOrr = 4'hC;
    localparam logic [3:0] AluMul = 4'hD;
    localparam logic [3:0] AluBic = 4'hE;
    localparam logic [3:0] AluMvn = 4'hF;

    typedef struct packed {
        logic [1:0]  status;
        logic        reg_write;
        logic [3:0]  reg_index;
        logic [31:0] reg_value;
        logic [3:0]  flags;
        logic        branch_taken;
        logic [31:0] branch_target;
        logic        thumb_state;
    } result_t;

endpackage

/* rtl/core/thumb_register_execute_unit.sv */
// An input transfer is registered into stage 1; its result is registered into the output
// register when stage 2 advances, and a stalled output holds the whole pipeline.
// Throughput: one instruction per cycle unless the output stalls; stage 1 reads two register
// file ports, stage 2 executes with forwarding from the write of the previous instruction.
// MUL uses one 32x32 multiplier in stage 2.
// Reset clears the register file valid bits and flags; registers read as zero until written.
module thumb_register_execute_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // instr[15:0], pc_value[47:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata    // status[1:0], reg_write[2], reg_index[6:3],
                                        // reg_value[38:7], flag_n[39], flag_z[40],
                                        // flag_c[41], flag_v[42], branch_taken[43],
                                        // branch_target[75:44], thumb_state[76], zero[79:77]
);

    logic [31:0] rf_mem [tre_pkg::RegCount];
    logic [14:0] rf_valid_reg;
    logic [31:0] rda_reg, rdb_reg;
    logic [3:0]  ia_reg, ib_reg;
    logic        e_valid_reg;
    logic [15:0] e_ins_reg;
    logic [31:0] e_pc_reg;
    logic [3:0]  flags_reg;
    logic        o_valid_reg;
    tre_pkg::result_t o_res_reg, res;
    logic        wb_en;
    logic [3:0]  wb_idx;
    logic [31:0] wb_val;
    logic        adv, e_ready;

    // Pipeline advances when the output register is free or being drained.
    assign e_ready       = !o_valid_reg || m_axis_tready;
    assign s_axis_tready = e_ready;
    assign adv           = s_axis_tvalid && s_axis_tready;

    // Read addresses chosen from the raw instruction; stage 2 muxes the needed operand.
    logic [15:0] in_ins;
    logic [3:0]  ra, rb;
    assign in_ins = s_axis_tdata[15:0];
    always_comb
    begin
        ra = {1'b0, in_ins[2:0]};
        rb = {1'b0, in_ins[5:3]};
        if (in_ins[15:11] == 5'h1F || in_ins[15:11] == 5'h1D)
            ra = 4'd14;
        else if (in_ins[15:13] == 3'b001 || in_ins[15:12] == 4'hA)
            ra = {1'b0, in_ins[10:8]};
        else if (in_ins[15:10] == 6'h11)
        begin
            ra = {in_ins[7], in_ins[2:0]};
            rb = in_ins[6:3];
        end
        else if (in_ins[15:11] == 5'h03)
        begin
            ra = {1'b0, in_ins[5:3]};
            rb = {1'b0, in_ins[8:6]};
        end
        else if (in_ins[15:13] == 3'b000 || in_ins[15:8] == 8'hB2)
            ra = {1'b0, in_ins[5:3]};
        if (in_ins[15:8] == 8'hB0 || (in_ins[15:12] == 4'hA && in_ins[11]))
            ra = 4'd13;
    end

    always_ff @(posedge clk)
    begin
        if (wb_en)
            rf_mem[wb_idx] <= wb_val;
        if (adv)
        begin
            rda_reg   <= (ra == 4'd15) ? 32'd0 : rf_mem[ra];
            rdb_reg   <= (rb == 4'd15) ? 32'd0 : rf_mem[rb];
            ia_reg    <= ra;
            ib_reg    <= rb;
            e_ins_reg <= in_ins;
            e_pc_reg  <= s_axis_tdata[47:16];
        end
    end

    // Forward the write made in the same cycle as the read, and apply valid bits.
    logic [31:0] fwd_a, fwd_b_raw, opa, opb;
    logic        fa_reg, fb_reg;
    logic [31:0] fva_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fa_reg  <= 1'b0;
            fb_reg  <= 1'b0;
        end
        else if (adv)
        begin
            fa_reg <= wb_en && wb_idx == ra;
            fb_reg <= wb_en && wb_idx == rb;
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv)
            fva_reg <= wb_val;
    end
    logic va_reg, vb_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= (ra != 4'd15) && rf_valid_reg[ra[3:0]];
            vb_reg <= (rb != 4'd15) && rf_valid_reg[rb[3:0]];
        end
    end
    assign fwd_a     = fa_reg ? fva_reg : (va_reg ? rda_reg : 32'd0);
    assign fwd_b_raw = fb_reg ? fva_reg : (vb_reg ? rdb_reg : 32'd0);
    assign opa = (ia_reg == 4'd15) ? e_pc_reg : fwd_a;
    assign opb = (ib_reg == 4'd15) ? e_pc_reg : fwd_b_raw;

    // Execute.
    logic [15:0] ins;
    logic [31:0] pc;
    logic        fn, fz, fc, fv;
    logic [32:0] sum;
    logic [31:0] ax, bx, sh_res, mul_res;
    logic        cin, sh_c;
    logic [7:0]  amt;
    logic        sh_left, sh_arith;
    logic        cond;
    logic [63:0] sh_w;
    assign ins = e_ins_reg;
    assign pc  = e_pc_reg;
    assign mul_res = opa * opb;

    always_comb
    begin
        sh_left = 1'b0;
        sh_arith = 1'b0;
        amt = 8'd0;
        if (ins[15:13] == 3'b000)
        begin
            sh_left  = ins[12:11] == 2'd0;
            sh_arith = ins[12:11] == 2'd2;
            amt = (ins[10:6] == 5'd0 && !sh_left) ? 8'd32 : {3'd0, ins[10:6]};
        end
        else
        begin
            sh_left = ins[9:6] == tre_pkg::AluLsl;
            amt = opb[7:0];
        end
        sh_c = flags_reg[1];
        sh_res = opa;
        sh_w = 64'd0;
        if (amt != 8'd0)
        begin
            if (amt < 8'd32)
            begin
                if (sh_left)
                begin
                    sh_w = {32'd0, opa} << amt[4:0];
                    sh_res = sh_w[31:0];
                    sh_c = sh_w[32];
                end
                else
                begin
                    sh_w = {(sh_arith && opa[31]) ? 32'hFFFFFFFF : 32'd0, opa} >> amt[4:0];
                    sh_res = sh_w[31:0];
                    sh_c = opa[amt[4:0] - 5'd1];
                end
            end
            else if (sh_arith)
            begin
                sh_res = {32{opa[31]}};
                sh_c = opa[31];
            end
            else
            begin
                sh_res = 32'd0;
                sh_c = (amt == 8'd32) ? (sh_left ? opa[0] : opa[31]) : 1'b0;
            end
        end
    end

    always_comb
    begin
        fn = flags_reg[3];
        fz = flags_reg[2];
        fc = flags_reg[1];
        fv = flags_reg[0];
        unique case (ins[11:8])
            4'd0:    cond = fz;
            4'd1:    cond = !fz;
            4'd2:    cond = fc;
            4'd3:    cond = !fc;
            4'd4:    cond = fn;
            4'd5:    cond = !fn;
            4'd6:    cond = fv;
            4'd7:    cond = !fv;
            4'd8:    cond = fc && !fz;
            4'd9:    cond = !fc || fz;
            4'd10:   cond = fn == fv;
            4'd11:   cond = fn != fv;
            4'd12:   cond = !fz && fn == fv;
            default: cond = fz || fn != fv;
        endcase
    end

    logic do_add, set_nz;
    logic [1:0]  st;
    logic [31:0] v;
    always_comb
    begin
        res = '0;
        res.thumb_state = 1'b1;
        res.flags = flags_reg;
        ax = opa;
        bx = opb;
        cin = 1'b0;
        do_add = 1'b0;
        set_nz = 1'b0;
        st = tre_pkg::StatusOk;
        v = 32'd0;
        if ((ins[15:12] == 4'hB && ins[10:9] == 2'd2) || ins[15:11] == 5'h09
            || ins[15:12] == 4'hC || ins[15:13] == 3'd3 || ins[15:12] == 4'h5
            || ins[15:12] == 4'h8 || ins[15:12] == 4'h9)
            res.status = tre_pkg::StatusMem;
        else if (ins[15:11] == 5'h1E)
        begin
            res.reg_write = 1'b1;
            res.reg_index = 4'd14;
            v = pc + {{9{ins[10]}}, ins[10:0], 12'd0};
        end
        else if (ins[15:11] == 5'h1F || ins[15:11] == 5'h1D)
        begin
            res.branch_target = opa + {20'd0, ins[10:0], 1'b0};
            if (!ins[12])
            begin
                res.branch_target[1:0] = 2'd0;
                res.thumb_state = 1'b0;
            end
            res.branch_taken = 1'b1;
            res.reg_write = 1'b1;
            res.reg_index = 4'd14;
            v = (pc - 32'd2) | 32'd1;
        end
        else if (ins[15:13] == 3'b001)
        begin
            res.reg_write = ins[12:11] != 2'd1;
            res.reg_index = {1'b0, ins[10:8]};
            bx = {24'd0, ins[7:0]};
            if (ins[12:11] == 2'd0)
            begin
                v = bx;
                set_nz = 1'b1;
            end
            else
            begin
                do_add = 1'b1;
                if (ins[12:11] != 2'd2)
                begin
                    bx = ~bx;
                    cin = 1'b1;
                end
            end
        end
        else if (ins[15:12] == 4'hD)
        begin
            if (ins[11:9] == 3'b111)
                res.status = tre_pkg::StatusUndef;
            else if (cond)
            begin
                res.branch_taken = 1'b1;
                res.branch_target = pc + {{23{ins[7]}}, ins[7:0], 1'b0};
            end
        end
        else if (ins[15:10] == 6'h11)
        begin
            unique case (ins[9:8])
                2'd0: res.status = tre_pkg::StatusUndef;
                2'd1:
                begin
                    bx = ~opb;
                    cin = 1'b1;
                    do_add = 1'b1;
                end
                2'd2:
                begin
                    if (ia_reg == 4'd15)
                    begin
                        res.branch_taken = 1'b1;
                        res.branch_target = {opb[31:1], 1'b0};
                    end
                    else
                    begin
                        res.reg_write = 1'b1;
                        res.reg_index = ia_reg;
                        v = opb;
                    end
                end
                default:
                begin
                    res.branch_taken = 1'b1;
                    res.branch_target = {opb[31:1], 1'b0};
                    res.thumb_state = opb[0];
                    if (ins[7])
                    begin
                        res.reg_write = 1'b1;
                        res.reg_index = 4'd14;
                        v = (pc - 32'd2) | 32'd1;
                    end
                end
            endcase
        end
        else if (ins[15:11] == 5'h03)
        begin
            res.reg_write = 1'b1;
            res.reg_index = {1'b0, ins[2:0]};
            do_add = 1'b1;
            if (ins[10])
                bx = {29'd0, ins[8:6]};
            if (ins[9])
            begin
                bx = ~bx;
                cin = 1'b1;
            end
        end
        else if (ins[15:13] == 3'b000)
        begin
            res.reg_write = 1'b1;
            res.reg_index = {1'b0, ins[2:0]};
            v = sh_res;
            res.flags[1] = sh_c;
            set_nz = 1'b1;
        end
        else if (ins[15:8] == 8'hB0)
        begin
            res.reg_write = 1'b1;
            res.reg_index = 4'd13;
            v = ins[7] ? opa - {23'd0, ins[6:0], 2'd0} : opa + {23'd0, ins[6:0], 2'd0};
        end
        else if (ins[15:10] == 6'h10)
        begin
            res.reg_write = 1'b1;
            res.reg_index = {1'b0, ins[2:0]};
            set_nz = 1'b1;
            case (ins[9:6])
                tre_pkg::AluAnd: v = opa & opb;
                tre_pkg::AluEor: v = opa ^ opb;
                tre_pkg::AluLsl, tre_pkg::AluLsr:
                begin
                    v = sh_res;
                    res.flags[1] = sh_c;
                end
                tre_pkg::AluAdc:
                begin
                    cin = fc;
                    do_add = 1'b1;
                    set_nz = 1'b0;
                end
                tre_pkg::AluSbc:
                begin
                    bx = ~opb;
                    cin = fc;
                    do_add = 1'b1;
                    set_nz = 1'b0;
                end
                tre_pkg::AluTst:
                begin
                    v = opa & opb;
                    res.reg_write = 1'b0;
                end
                tre_pkg::AluCmp:
                begin
                    bx = ~opb;
                    cin = 1'b1;
                    do_add = 1'b1;
                    set_nz = 1'b0;
                    res.reg_write = 1'b0;
                end
                tre_pkg::AluOrr: v = opa | opb;
                tre_pkg::AluMul: v = mul_res;
                tre_pkg::AluBic: v = opa & ~opb;
                tre_pkg::AluMvn: v = ~opb;
                default:
                begin
                    res.status = tre_pkg::StatusUndef;
                    set_nz = 1'b0;
                end
            endcase
        end
        else if (ins[15:11] == 5'h1C)
        begin
            res.branch_taken = 1'b1;
            res.branch_target = pc + {{20{ins[10]}}, ins[10:0], 1'b0};
        end
        else if (ins[15:12] == 4'hA)
        begin
            res.reg_write = 1'b1;
            res.reg_index = {1'b0, ins[10:8]};
            v = (ins[11] ? opa : {pc[31:2], 2'd0}) + {22'd0, ins[7:0], 2'd0};
        end
        else if (ins[15:8] == 8'hB2)
        begin
            res.reg_write = 1'b1;
            res.reg_index = {1'b0, ins[2:0]};
            unique case (ins[7:6])
                2'd0: v = {{16{opa[15]}}, opa[15:0]};
                2'd1: v = {{24{opa[7]}}, opa[7:0]};
                2'd2: v = {16'd0, opa[15:0]};
                default: v = {24'd0, opa[7:0]};
            endcase
        end
        else
            res.status = tre_pkg::StatusUndef;

        sum = {1'b0, ax} + {1'b0, bx} + {32'd0, cin};
        if (do_add)
        begin
            v = sum[31:0];
            res.flags = {sum[31], sum[31:0] == 32'd0, sum[32],
                         ~(ax[31] ^ bx[31]) & (ax[31] ^ sum[31])};
        end
        else if (set_nz)
            res.flags[3:2] = {v[31], v == 32'd0};
        if (res.reg_write)
            res.reg_value = v;
        else
            res.reg_index = 4'd0;
        // A rejected instruction reports only its status and leaves the flags as they were.
        if (res.status != tre_pkg::StatusOk)
        begin
            st = res.status;
            res = '0;
            res.status = st;
            res.thumb_state = 1'b1;
            res.flags = flags_reg;
        end
    end

    assign wb_en  = e_valid_reg && e_ready && res.reg_write;
    assign wb_idx = res.reg_index;
    assign wb_val = res.reg_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg  <= 1'b0;
            o_valid_reg  <= 1'b0;
            flags_reg    <= 4'd0;
            rf_valid_reg <= '0;
        end
        else
        begin
            if (e_ready)
            begin
                e_valid_reg <= adv;
                o_valid_reg <= e_valid_reg;
                if (e_valid_reg)
                    flags_reg <= res.flags;
                if (wb_en)
                    rf_valid_reg[wb_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_ready && e_valid_reg)
            o_res_reg <= res;
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = {3'd0, o_res_reg.thumb_state, o_res_reg.branch_target,
                            o_res_reg.branch_taken, o_res_reg.flags[0], o_res_reg.flags[1],
                            o_res_reg.flags[2], o_res_reg.flags[3], o_res_reg.reg_value,
                            o_res_reg.reg_index, o_res_reg.reg_write, o_res_reg.status};

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;

    typedef struct packed {
        logic [31:0] pc_value;
        logic [15:0] instr;
    } instr_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        reg_write;
        logic [3:0]  reg_index;
        logic [31:0] reg_value;
        logic        flag_n;
        logic        flag_z;
        logic        flag_c;
        logic        flag_v;
        logic        branch_taken;
        logic [31:0] branch_target;
        logic        thumb_state;
    } exec_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;

    thumb_register_execute_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Shadow architectural state.
    logic [31:0] shadow_regs [tre_pkg::RegCount];
    logic        sn, sz, sc, sv;

    instr_item_t  pending_instrs [$];
    exec_result_t expected_results [$];

    int  error_count = 0;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_req;
    bit  hold_active;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] read_reg(input logic [3:0] idx, input logic [31:0] pc);
        return (idx == 4'd15) ? pc : shadow_regs[idx];
    endfunction

    function automatic void update_nz(input logic [31:0] r);
        sn = r[31];
        sz = (r == 32'd0);
    endfunction

    function automatic logic [31:0] add_with_carry(input logic [31:0] a, input logic [31:0] b,
                                                    input logic cin);
        logic [32:0] s;
        s  = {1'b0, a} + {1'b0, b} + {32'd0, cin};
        sc = s[32];
        sv = (~(a[31] ^ b[31])) & (a[31] ^ s[31]);
        update_nz(s[31:0]);
        return s[31:0];
    endfunction

    function automatic logic [31:0] shift_left(input logic [31:0] x, input logic [31:0] amt);
        if (amt == 32'd0)
            return x;
        if (amt < 32'd32)
        begin
            sc = x[32'd32 - amt];
            return x << amt;
        end
        sc = (amt == 32'd32) ? x[0] : 1'b0;
        return 32'd0;
    endfunction

    function automatic logic [31:0] shift_right(input logic [31:0] x, input logic [31:0] amt);
        if (amt == 32'd0)
            return x;
        if (amt < 32'd32)
        begin
            sc = x[amt - 32'd1];
            return x >> amt;
        end
        sc = (amt == 32'd32) ? x[31] : 1'b0;
        return 32'd0;
    endfunction

    function automatic logic [31:0] shift_arith(input logic [31:0] x, input logic [31:0] amt);
        if (amt == 32'd0)
            return x;
        if (amt < 32'd32)
        begin
            sc = x[amt - 32'd1];
            return $unsigned($signed(x) >>> amt);
        end
        sc = x[31];
        return {32{x[31]}};
    endfunction

    function automatic logic condition_passes(input logic [3:0] c);
        case (c)
            4'd0:    return sz;
            4'd1:    return !sz;
            4'd2:    return sc;
            4'd3:    return !sc;
            4'd4:    return sn;
            4'd5:    return !sn;
            4'd6:    return sv;
            4'd7:    return !sv;
            4'd8:    return sc && !sz;
            4'd9:    return !sc || sz;
            4'd10:   return sn == sv;
            4'd11:   return sn != sv;
            4'd12:   return !sz && (sn == sv);
            default: return sz || (sn != sv);
        endcase
    endfunction

    function automatic exec_result_t execute_instr(input logic [15:0] ins,
                                                   input logic [31:0] pc);
        exec_result_t r;
        logic [3:0]  saved;
        logic [2:0]  lo, mid, r8;
        logic [7:0]  imm8;
        logic [10:0] imm11;
        logic [31:0] a, b, wval, tgt;
        logic [3:0]  d, s, alu_op;
        logic [1:0]  op;
        logic        wr, br, thumb;
        logic [1:0]  status;
        logic [3:0]  widx;
        logic [4:0]  offs;

        saved = {sn, sz, sc, sv};
        lo = ins[2:0]; mid = ins[5:3]; r8 = ins[10:8];
        imm8 = ins[7:0]; imm11 = ins[10:0];
        status = tre_pkg::StatusOk; wr = 1'b0; widx = 4'd0; wval = 32'd0;
        br = 1'b0; tgt = 32'd0; thumb = 1'b1;

        if ((ins[15:12] == 4'hB && ins[10:9] == 2'd2) || ins[15:11] == 5'h09 ||
            ins[15:12] == 4'hC || ins[15:13] == 3'd3 || ins[15:12] == 4'h5 ||
            ins[15:12] == 4'h8 || ins[15:12] == 4'h9)
            status = tre_pkg::StatusMem;
        else if (ins[15:11] == 5'h1E)
        begin
            wr = 1'b1; widx = 4'd14;
            wval = pc + ({{21{imm11[10]}}, imm11} << 12);
        end
        else if (ins[15:11] == 5'h1F || ins[15:11] == 5'h1D)
        begin
            tgt = shadow_regs[14] + {20'd0, imm11, 1'b0};
            if (ins[15:11] == 5'h1D)
            begin
                tgt[1:0] = 2'b00;
                thumb = 1'b0;
            end
            br = 1'b1; wr = 1'b1; widx = 4'd14; wval = (pc - 32'd2) | 32'd1;
        end
        else if (ins[15:13] == 3'd1)
        begin
            a = shadow_regs[r8];
            wr = 1'b1; widx = {1'b0, r8};
            case (ins[12:11])
                2'd0:
                begin
                    wval = {24'd0, imm8};
                    update_nz(wval);
                end
                2'd1:
                begin
                    void'(add_with_carry(a, ~{24'd0, imm8}, 1'b1));
                    wr = 1'b0;
                end
                2'd2:    wval = add_with_carry(a, {24'd0, imm8}, 1'b0);
                default: wval = add_with_carry(a, ~{24'd0, imm8}, 1'b1);
            endcase
        end
        else if (ins[15:12] == 4'hD)
        begin
            if (ins[11:8] >= 4'd14)
                status = tre_pkg::StatusUndef;
            else if (condition_passes(ins[11:8]))
            begin
                br = 1'b1;
                tgt = pc + {{23{imm8[7]}}, imm8, 1'b0};
            end
        end
        else if (ins[15:10] == 6'h11)
        begin
            op = ins[9:8];
            d = {ins[7], lo};
            s = {ins[6], mid};
            a = read_reg(d, pc);
            b = read_reg(s, pc);
            if (op == 2'd0)
                status = tre_pkg::StatusUndef;
            else if (op == 2'd1)
                void'(add_with_carry(a, ~b, 1'b1));
            else if (op == 2'd2)
            begin
                if (d == 4'd15)
                begin
                    br = 1'b1; tgt = {b[31:1], 1'b0};
                end
                else
                begin
                    wr = 1'b1; widx = d; wval = b;
                end
            end
            else
            begin
                br = 1'b1; tgt = {b[31:1], 1'b0}; thumb = b[0];
                if (ins[7])
                begin
                    wr = 1'b1; widx = 4'd14; wval = (pc - 32'd2) | 32'd1;
                end
            end
        end
        else if (ins[15:11] == 5'h03)
        begin
            a = shadow_regs[mid];
            b = ins[10] ? {29'd0, ins[8:6]} : shadow_regs[ins[8:6]];
            wr = 1'b1; widx = {1'b0, lo};
            wval = ins[9] ? add_with_carry(a, ~b, 1'b1) : add_with_carry(a, b, 1'b0);
        end
        else if (ins[15:13] == 3'd0)
        begin
            offs = ins[10:6];
            a = shadow_regs[mid];
            if (ins[12:11] == 2'd0)
                wval = shift_left(a, {27'd0, offs});
            else if (ins[12:11] == 2'd1)
                wval = shift_right(a, (offs != 5'd0) ? {27'd0, offs} : 32'd32);
            else
                wval = shift_arith(a, (offs != 5'd0) ? {27'd0, offs} : 32'd32);
            update_nz(wval);
            wr = 1'b1; widx = {1'b0, lo};
        end
        else if (ins[15:8] == 8'hB0)
        begin
            wr = 1'b1; widx = 4'd13;
            wval = ins[7] ? shadow_regs[13] - {23'd0, ins[6:0], 2'b00}
                          : shadow_regs[13] + {23'd0, ins[6:0], 2'b00};
        end
        else if (ins[15:10] == 6'h10)
        begin
            alu_op = ins[9:6];
            a = shadow_regs[lo];
            b = shadow_regs[mid];
            wr = 1'b1; widx = {1'b0, lo};
            case (alu_op)
                tre_pkg::AluAnd: begin wval = a & b; update_nz(wval); end
                tre_pkg::AluEor: begin wval = a ^ b; update_nz(wval); end
                tre_pkg::AluLsl:
                begin
                    wval = shift_left(a, {24'd0, b[7:0]});
                    update_nz(wval);
                end
                tre_pkg::AluLsr:
                begin
                    wval = shift_right(a, {24'd0, b[7:0]});
                    update_nz(wval);
                end
                tre_pkg::AluAdc: wval = add_with_carry(a, b, sc);
                tre_pkg::AluSbc: wval = add_with_carry(a, ~b, sc);
                tre_pkg::AluTst: begin update_nz(a & b); wr = 1'b0; end
                tre_pkg::AluCmp: begin void'(add_with_carry(a, ~b, 1'b1)); wr = 1'b0; end
                tre_pkg::AluOrr: begin wval = a | b; update_nz(wval); end
                tre_pkg::AluMul: begin wval = a * b; update_nz(wval); end
                tre_pkg::AluBic: begin wval = a & ~b; update_nz(wval); end
                tre_pkg::AluMvn: begin wval = ~b; update_nz(wval); end
                default:
                begin
                    status = tre_pkg::StatusUndef; wr = 1'b0;
                end
            endcase
        end
        else if (ins[15:11] == 5'h1C)
        begin
            br = 1'b1;
            tgt = pc + {{20{imm11[10]}}, imm11, 1'b0};
        end
        else if (ins[15:12] == 4'hA)
        begin
            a = ins[11] ? shadow_regs[13] : {pc[31:2], 2'b00};
            wr = 1'b1; widx = {1'b0, r8};
            wval = a + {22'd0, imm8, 2'b00};
        end
        else if (ins[15:8] == 8'hB2)
        begin
            a = shadow_regs[mid];
            case (ins[7:6])
                2'd0:    wval = {{16{a[15]}}, a[15:0]};
                2'd1:    wval = {{24{a[7]}}, a[7:0]};
                2'd2:    wval = {16'd0, a[15:0]};
                default: wval = {24'd0, a[7:0]};
            endcase
            wr = 1'b1; widx = {1'b0, lo};
        end
        else
            status = tre_pkg::StatusUndef;

        if (status != tre_pkg::StatusOk)
        begin
            wr = 1'b0; widx = 4'd0; wval = 32'd0; br = 1'b0; tgt = 32'd0; thumb = 1'b1;
            {sn, sz, sc, sv} = saved;
        end
        else
        begin
            if (wr && widx < 4'd15)
                shadow_regs[widx] = wval;
            if (!wr)
            begin
                widx = 4'd0; wval = 32'd0;
            end
            if (!br)
                tgt = 32'd0;
        end

        r.status = status; r.reg_write = wr; r.reg_index = widx; r.reg_value = wval;
        r.flag_n = sn; r.flag_z = sz; r.flag_c = sc; r.flag_v = sv;
        r.branch_taken = br; r.branch_target = tgt; r.thumb_state = thumb;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Driver: offers the head of the pending queue, with random idle cycles.
    // An offered transfer stays unchanged until it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                void'(pending_instrs.pop_front());
            if (s_axis_tvalid && !s_axis_tready)
            begin
                s_axis_tvalid <= 1'b1;
            end
            else if (pending_instrs.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_instrs[0];
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Prediction happens at input acceptance, in transfer order.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tre_pkg::RegCount; i++)
                shadow_regs[i] = 32'd0;
            {sn, sz, sc, sv} = 4'd0;
        end
        else if (s_axis_tvalid && s_axis_tready)
            expected_results.push_back(execute_instr(s_axis_tdata[15:0], s_axis_tdata[47:16]));
    end

    // Long receiver hold, counted here once requested.
    initial
    begin
        hold_active = 1'b0;
        wait (hold_req);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (200) @(posedge clk);
        hold_active <= 1'b0;
    end

    // Receiver backpressure; a forced hold overrides the random stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_active)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor.
    always @(posedge clk)
    begin
        exec_result_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{m_axis_tdata[1:0], m_axis_tdata[2], m_axis_tdata[6:3], m_axis_tdata[38:7],
                    m_axis_tdata[39], m_axis_tdata[40], m_axis_tdata[41], m_axis_tdata[42],
                    m_axis_tdata[43], m_axis_tdata[75:44], m_axis_tdata[76]};
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", {16'd0, 16'hffff}, 32'd0);
            else
            begin
                want = expected_results.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.reg_write != want.reg_write)
                    report_mismatch("reg_write", 32'(got.reg_write), 32'(want.reg_write));
                if (got.reg_index != want.reg_index)
                    report_mismatch("reg_index", 32'(got.reg_index), 32'(want.reg_index));
                if (got.reg_value != want.reg_value)
                    report_mismatch("reg_value", got.reg_value, want.reg_value);
                if (got.flag_n != want.flag_n)
                    report_mismatch("flag_n", 32'(got.flag_n), 32'(want.flag_n));
                if (got.flag_z != want.flag_z)
                    report_mismatch("flag_z", 32'(got.flag_z), 32'(want.flag_z));
                if (got.flag_c != want.flag_c)
                    report_mismatch("flag_c", 32'(got.flag_c), 32'(want.flag_c));
                if (got.flag_v != want.flag_v)
                    report_mismatch("flag_v", 32'(got.flag_v), 32'(want.flag_v));
                if (got.branch_taken != want.branch_taken)
                    report_mismatch("branch_taken", 32'(got.branch_taken),
                                    32'(want.branch_taken));
                if (got.branch_target != want.branch_target)
                    report_mismatch("branch_target", got.branch_target, want.branch_target);
                if (got.thumb_state != want.thumb_state)
                    report_mismatch("thumb_state", 32'(got.thumb_state),
                                    32'(want.thumb_state));
            end
        end
    end

    function automatic logic [15:0] random_instr();
        logic [15:0] w;
        w = 16'($urandom);
        // Weight toward the register-only groups so that state builds up.
        case ($urandom_range(11))
            0:       w[15:13] = 3'b001;
            1:       w[15:13] = 3'b000;
            2:       w[15:11] = 5'b00011;
            3:       w[15:10] = 6'b010000;
            4:       w[15:10] = 6'b010001;
            5:       w[15:12] = 4'hD;
            6:       w[15:8]  = ($urandom_range(1)) ? 8'hB0 : 8'hB2;
            7:       w[15:12] = 4'hA;
            8:       w[15:11] = 5'($urandom_range(5'h1C, 5'h1F));
            9:       w[15:8]  = 8'h20 | 8'($urandom_range(7));
            default: ;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] random_pc();
        case ($urandom_range(7))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_instr(input logic [15:0] ins, input logic [31:0] pc);
        pending_instrs.push_back('{pc_value: pc, instr: ins});
    endtask

    task automatic wait_drained();
        while (pending_instrs.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        rst_n         <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: immediates, extreme shifts, ALU corner cases, branches, BL and rejected encodings.
        queue_instr(16'h20FF, 32'd4);          // mov r0,#255
        queue_instr(16'h2180, 32'd4);          // mov r1,#128
        queue_instr(16'h3801, 32'd4);          // sub r0,#1
        queue_instr(16'h0FC2, 32'd4);          // lsr r2,r0,#31
        queue_instr(16'h0803, 32'd4);          // lsr r3,r0,#32
        queue_instr(16'h07C4, 32'd4);          // lsl r4,r0,#31
        queue_instr(16'h43C5, 32'hFFFF_FFFF);  // mvn r5,r0
        queue_instr(16'h40CD, 32'd0);          // lsr r5,r1 (shift by 128)
        queue_instr(16'h41AD, 32'd0);          // sbc r5,r5
        queue_instr(16'h4344, 32'd0);          // mul r4,r0
        queue_instr(16'h4280, 32'd0);          // cmp r0,r0
        queue_instr(16'h4100, 32'd0);          // asr (undefined)
        queue_instr(16'h4468, 32'd0);          // hi add (undefined)
        queue_instr(16'h46FF, 32'h1235);       // mov pc,pc
        queue_instr(16'h4778, 32'h8001);       // bx pc
        queue_instr(16'h47C8, 32'h100);        // blx r9
        queue_instr(16'hB07F, 32'd0);          // add sp,#508
        queue_instr(16'hB0FF, 32'd0);          // sub sp,#508
        queue_instr(16'hA7FF, 32'hFFFF_FFFF);  // add r7,pc,#1020
        queue_instr(16'hB2C2, 32'd0);          // uxtb r2,r0
        queue_instr(16'hD080, 32'h1000);       // beq back
        queue_instr(16'hDE00, 32'd0);          // cond 14 (undefined)
        queue_instr(16'hF7FF, 32'h2000);       // bl prefix, negative
        queue_instr(16'hEFFF, 32'h2002);       // blx suffix
        queue_instr(16'hB500, 32'd0);          // push (memory)
        wait_drained();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                3: begin send_idle_pct = 28; recv_stall_pct = 28; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int n = 0; n < 180; n++)
                queue_instr(random_instr(), random_pc());
            if (phase == 4)
            begin
                // Long receiver hold while the sender keeps offering.
                @(posedge clk);
                hold_req = 1'b1;
            end
            wait_drained();
        end
        repeat (10) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("PASS thumb_register_execute_unit");
        else
            $display("FAIL thumb_register_execute_unit");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL thumb_register_execute_unit");
        $finish;
    end
endmodule
